>>> design/assert_macros.svh
// assertion macros used by the checker file tfc_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define TFC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tfc check failed");

// property checked only while a qualifying valid is high
`define TFC_ASSERT_VALID(label, clk, rst_n, vld, prop) \
  `TFC_ASSERT(label, clk, rst_n, (vld) |-> (prop))

`endif

>>> design/tfc_pkg.sv
// types and constants of the thermal fan controller
// no dependencies
package tfc_pkg;

  localparam int unsigned TempW  = 12;
  localparam int unsigned DutyW  = 13;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned LvlW   = 4;
  localparam int unsigned PageW  = 3;
  localparam int unsigned MotorW = 2;
  localparam int unsigned CmdW   = 2;

  typedef enum logic [CmdW-1:0] {
    CmdSample = 2'd0,
    CmdOption = 2'd1,
    CmdInc    = 2'd2,
    CmdDec    = 2'd3
  } cmd_e;

  typedef enum logic [MotorW-1:0] {
    MotorOff      = 2'd0,
    MotorLow      = 2'd1,
    MotorHigh     = 2'd2,
    MotorShutdown = 2'd3
  } motor_e;

  typedef enum logic [PageW-1:0] {
    PageRun       = 3'd0,
    PageLowThr    = 3'd1,
    PageHighThr   = 3'd2,
    PageDangerThr = 3'd3,
    PageLowLvl    = 3'd4,
    PageHighLvl   = 3'd5
  } page_e;

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic signed [ThrW-1:0]  thr_t;
  typedef logic        [LvlW-1:0]  lvl_t;
  typedef logic        [DutyW-1:0] duty_t;

  localparam thr_t  DangerCeil   = 8'sd125;
  localparam thr_t  LowFloor     = -8'sd55;
  localparam duty_t DutyMax      = 13'h1FFF;

  localparam thr_t  LowThrRst    = 8'sd25;
  localparam thr_t  HighThrRst   = 8'sd30;
  localparam thr_t  DangerThrRst = 8'sd70;
  localparam lvl_t  LowLvlRst    = 4'd4;
  localparam lvl_t  HighLvlRst   = 4'd9;

endpackage

>>> design/tfc_if.sv
// valid/ready channels of the thermal fan controller
// depends on tfc_pkg
interface tfc_in_if;
  logic                       valid;
  logic                       ready;
  logic [tfc_pkg::CmdW-1:0]   cmd;
  logic signed [tfc_pkg::TempW-1:0] temp_sixteenths;

  modport source (output valid, cmd, temp_sixteenths, input ready);
  modport sink   (input valid, cmd, temp_sixteenths, output ready);
endinterface

interface tfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tfc_pkg::DutyW-1:0]    pwm_compare;
  logic [tfc_pkg::MotorW-1:0]   motor_state;
  logic [tfc_pkg::PageW-1:0]    menu_page_out;
  logic signed [tfc_pkg::ThrW-1:0] page_value;
  logic                         shutdown_latched;

  modport source (output valid, pwm_compare, motor_state, menu_page_out, page_value,
                  shutdown_latched, input ready);
  modport sink   (input valid, pwm_compare, motor_state, menu_page_out, page_value,
                  shutdown_latched, output ready);
endinterface

>>> design/thermal_fan_controller_with_menu.sv
// thermal fan controller with settings menu: one result per sample or button event
// a result passes the input register, then the result register
// throughput: one item per cycle while the output is not stalled; the settings and control
// state update once per item, so the next item sees it without a bubble
// reset: asynchronous active low; settings return to their defaults, both stages empty
// depends on tfc_pkg and tfc_if
module thermal_fan_controller_with_menu #(
  parameter int unsigned DUTY_STEP       = 500,
  parameter int unsigned MAX_MOTOR_LEVEL = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfc_in_if.sink    in_i,
  tfc_out_if.source out_o
);

  localparam int unsigned LvlW    = tfc_pkg::LvlW;
  localparam int unsigned ThrW    = tfc_pkg::ThrW;
  localparam int unsigned DutyW   = tfc_pkg::DutyW;
  localparam int unsigned ProdRaw = $clog2(DUTY_STEP * ((1 << LvlW) - 1) + 1);
  localparam int unsigned ProdW   = (ProdRaw > DutyW) ? ProdRaw : DutyW + 1;
  localparam logic [ProdW-1:0]   StepVal  = ProdW'(DUTY_STEP);
  localparam logic [ProdW-1:0]   DutyMaxW = ProdW'(tfc_pkg::DutyMax);
  localparam tfc_pkg::lvl_t      MaxLevel = LvlW'(MAX_MOTOR_LEVEL);

  // input stage
  logic                  s1_valid_q;
  tfc_pkg::cmd_e         s1_cmd_q;
  tfc_pkg::temp_t        s1_temp_q;
  logic                  out_free;
  logic                  s1_fire;

  // settings and control state
  tfc_pkg::temp_t  temp_q, temp_d;
  tfc_pkg::page_e  page_q, page_d;
  tfc_pkg::thr_t   low_q, low_d, high_q, high_d, danger_q, danger_d;
  tfc_pkg::lvl_t   llvl_q, llvl_d, hlvl_q, hlvl_d;
  logic            run_q, run_d;
  tfc_pkg::duty_t  duty_q, duty_d;
  tfc_pkg::motor_e level_q, level_d;

  // result register
  logic            out_valid_q;
  tfc_pkg::duty_t  out_pwm_q;
  tfc_pkg::motor_e out_motor_q;
  tfc_pkg::page_e  out_page_q;
  tfc_pkg::thr_t   out_pv_q;
  logic            out_shut_q;
  tfc_pkg::thr_t   pv_d;

  // widened settings arithmetic
  logic signed [ThrW:0] low_x, high_x, danger_x;
  logic signed [ThrW:0] low_p1, high_p1, high_m1, danger_m1;
  tfc_pkg::thr_t        low_up, low_dn, high_up, high_dn, danger_up, danger_dn;
  logic [LvlW:0]        llvl_p1, hlvl_p1, llvl_x, hlvl_x;
  tfc_pkg::lvl_t        llvl_up, llvl_dn, hlvl_up, hlvl_dn;

  // control thresholds and duties
  tfc_pkg::temp_t       low_s, high_s, danger_s;
  logic [ProdW-1:0]     prod_low, prod_high;
  tfc_pkg::duty_t       duty_low, duty_high;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_cmd_q  <= tfc_pkg::cmd_e'(in_i.cmd);
      s1_temp_q <= in_i.temp_sixteenths;
    end
  end

  assign low_x     = {low_q[ThrW-1], low_q};
  assign high_x    = {high_q[ThrW-1], high_q};
  assign danger_x  = {danger_q[ThrW-1], danger_q};
  assign low_p1    = low_x + 9'sd1;
  assign high_p1   = high_x + 9'sd1;
  assign high_m1   = high_x - 9'sd1;
  assign danger_m1 = danger_x - 9'sd1;

  assign low_up    = (low_p1 >= high_x) ? high_q : low_p1[ThrW-1:0];
  assign low_dn    = (low_q > tfc_pkg::LowFloor) ? ThrW'(low_q - 8'sd1) : low_q;
  assign high_up   = (high_p1 >= danger_x) ? danger_q : high_p1[ThrW-1:0];
  assign high_dn   = (high_m1 <= low_x) ? low_q : high_m1[ThrW-1:0];
  assign danger_up = (danger_q < tfc_pkg::DangerCeil) ? ThrW'(danger_q + 8'sd1) : danger_q;
  assign danger_dn = (danger_m1 <= high_x) ? high_q : danger_m1[ThrW-1:0];

  assign llvl_x  = {1'b0, llvl_q};
  assign hlvl_x  = {1'b0, hlvl_q};
  assign llvl_p1 = llvl_x + 5'd1;
  assign hlvl_p1 = hlvl_x + 5'd1;
  assign llvl_up = (llvl_p1 >= hlvl_x) ? hlvl_q : llvl_p1[LvlW-1:0];
  assign llvl_dn = (llvl_q == '0) ? '0 : LvlW'(llvl_q - 4'd1);
  assign hlvl_up = (hlvl_p1 > {1'b0, MaxLevel}) ? MaxLevel : hlvl_p1[LvlW-1:0];
  assign hlvl_dn = (hlvl_x <= llvl_p1) ? llvl_q : LvlW'(hlvl_q - 4'd1);

  // settings do not change on the run page, so the stored values feed the rule
  assign low_s    = {low_q, 4'b0000};
  assign high_s   = {high_q, 4'b0000};
  assign danger_s = {danger_q, 4'b0000};

  assign prod_low  = ProdW'(llvl_q) * StepVal;
  assign prod_high = ProdW'(hlvl_q) * StepVal;
  assign duty_low  = (prod_low > DutyMaxW) ? tfc_pkg::DutyMax : prod_low[DutyW-1:0];
  assign duty_high = (prod_high > DutyMaxW) ? tfc_pkg::DutyMax : prod_high[DutyW-1:0];

  always_comb begin
    temp_d   = temp_q;
    page_d   = page_q;
    low_d    = low_q;
    high_d   = high_q;
    danger_d = danger_q;
    llvl_d   = llvl_q;
    hlvl_d   = hlvl_q;
    run_d    = run_q;
    duty_d   = duty_q;
    level_d  = level_q;
    pv_d     = '0;

    case (s1_cmd_q)
      tfc_pkg::CmdSample: begin
        temp_d = s1_temp_q;
      end
      tfc_pkg::CmdOption: begin
        page_d = (page_q >= tfc_pkg::PageHighLvl) ? tfc_pkg::PageRun
                                                  : tfc_pkg::page_e'(page_q + 3'd1);
      end
      tfc_pkg::CmdInc: begin
        case (page_q)
          tfc_pkg::PageLowThr:    low_d    = low_up;
          tfc_pkg::PageHighThr:   high_d   = high_up;
          tfc_pkg::PageDangerThr: danger_d = danger_up;
          tfc_pkg::PageLowLvl:    llvl_d   = llvl_up;
          tfc_pkg::PageHighLvl:   hlvl_d   = hlvl_up;
          default: ;
        endcase
      end
      tfc_pkg::CmdDec: begin
        case (page_q)
          tfc_pkg::PageLowThr:    low_d    = low_dn;
          tfc_pkg::PageHighThr:   high_d   = high_dn;
          tfc_pkg::PageDangerThr: danger_d = danger_dn;
          tfc_pkg::PageLowLvl:    llvl_d   = llvl_dn;
          tfc_pkg::PageHighLvl:   hlvl_d   = hlvl_dn;
          default: ;
        endcase
      end
      default: ;
    endcase

    if (page_d == tfc_pkg::PageRun) begin
      if (temp_d <= low_s) begin
        duty_d  = '0;
        run_d   = 1'b1;
        level_d = tfc_pkg::MotorOff;
      end
      if (temp_d > low_s && run_d) begin
        duty_d  = duty_low;
        level_d = tfc_pkg::MotorLow;
      end
      if (temp_d >= high_s && run_d) begin
        duty_d  = duty_high;
        level_d = tfc_pkg::MotorHigh;
      end
      if (temp_d > danger_s) begin
        duty_d  = '0;
        run_d   = 1'b0;
        level_d = tfc_pkg::MotorShutdown;
      end
      if (!run_d) begin
        level_d = tfc_pkg::MotorShutdown;
      end
    end

    case (page_d)
      tfc_pkg::PageLowThr:    pv_d = low_d;
      tfc_pkg::PageHighThr:   pv_d = high_d;
      tfc_pkg::PageDangerThr: pv_d = danger_d;
      tfc_pkg::PageLowLvl:    pv_d = ThrW'(llvl_d);
      tfc_pkg::PageHighLvl:   pv_d = ThrW'(hlvl_d);
      default:                pv_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q   <= '0;
      page_q   <= tfc_pkg::PageRun;
      low_q    <= tfc_pkg::LowThrRst;
      high_q   <= tfc_pkg::HighThrRst;
      danger_q <= tfc_pkg::DangerThrRst;
      llvl_q   <= tfc_pkg::LowLvlRst;
      hlvl_q   <= tfc_pkg::HighLvlRst;
      run_q    <= 1'b1;
      duty_q   <= '0;
      level_q  <= tfc_pkg::MotorOff;
    end else if (s1_fire) begin
      temp_q   <= temp_d;
      page_q   <= page_d;
      low_q    <= low_d;
      high_q   <= high_d;
      danger_q <= danger_d;
      llvl_q   <= llvl_d;
      hlvl_q   <= hlvl_d;
      run_q    <= run_d;
      duty_q   <= duty_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pwm_q   <= duty_d;
      out_motor_q <= level_d;
      out_page_q  <= page_d;
      out_pv_q    <= pv_d;
      out_shut_q  <= !run_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.pwm_compare      = out_pwm_q;
  assign out_o.motor_state      = out_motor_q;
  assign out_o.menu_page_out    = out_page_q;
  assign out_o.page_value       = out_pv_q;
  assign out_o.shutdown_latched = out_shut_q;

endmodule

>>> design/tfc_checker.sv
// port-level checks of the thermal fan controller, bound to the top level
// depends on tfc_pkg and assert_macros.svh
`include "assert_macros.svh"

module tfc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [tfc_pkg::DutyW-1:0]      out_pwm_compare_i,
  input logic [tfc_pkg::MotorW-1:0]     out_motor_state_i,
  input logic [tfc_pkg::PageW-1:0]      out_menu_page_out_i,
  input logic signed [tfc_pkg::ThrW-1:0] out_page_value_i,
  input logic                           out_shutdown_latched_i
);

  // stalled result keeps its duty
  `TFC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pwm_compare_i))

  // latch flag and shutdown state agree
  `TFC_ASSERT_VALID(a_shutdown_state, clk_i, rst_ni, out_valid_i, out_shutdown_latched_i == (out_motor_state_i == tfc_pkg::MotorShutdown))

  // motor off or shut down drives no duty
  `TFC_ASSERT_VALID(a_off_no_duty, clk_i, rst_ni, out_valid_i && (out_motor_state_i == tfc_pkg::MotorOff || out_motor_state_i == tfc_pkg::MotorShutdown), out_pwm_compare_i == '0)

  // run page shows no setting
  `TFC_ASSERT_VALID(a_run_page_blank, clk_i, rst_ni, out_valid_i && out_menu_page_out_i == tfc_pkg::PageRun, out_page_value_i == '0)

endmodule

bind thermal_fan_controller_with_menu tfc_checker u_tfc_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .out_pwm_compare_i      (out_o.pwm_compare),
  .out_motor_state_i      (out_o.motor_state),
  .out_menu_page_out_i    (out_o.menu_page_out),
  .out_page_value_i       (out_o.page_value),
  .out_shutdown_latched_i (out_o.shutdown_latched)
);
